@@ rtl/core/ptm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

  // Sample and range widths
  localparam int SAMPLE_BITS = 24;
  localparam int P2P_BITS    = 24;

  // Output queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  // Final mark of one sample
  typedef enum logic [1:0] {
    MARK_NEITHER = 2'd0,
    MARK_PEAK    = 2'd1,
    MARK_TROUGH  = 2'd2
  } marker_e;

  // Input beat
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_record;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    marker_e               marker;
    logic [P2P_BITS-1:0]   peak_to_peak;
    logic                  last_result;
  } out_beat_t;

  // Results produced by one accepted sample: the held sample's marker first,
  // then the end-of-record beat
  typedef struct packed {
    logic      mark_vld;
    out_beat_t mark_beat;
    logic      end_vld;
    out_beat_t end_beat;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/core/ptm_mark.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptm_mark (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire ptm_pkg::in_beat_t in_i,
  output ptm_pkg::push_t        push_o
);
  import ptm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] prior_sample_q, prior_sample_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  marker_e                       prior_marker_q, prior_marker_d;
  logic                          have_prior_q, have_prior_d;
  logic                          prior_first_q, prior_first_d;

  logic                          rise;
  logic                          fall;
  marker_e                       new_mark;
  marker_e                       revised;
  logic [SAMPLE_BITS-1:0]        range;

  // Classify the step against the held sample
  assign rise = in_i.sample > prior_sample_q;
  assign fall = in_i.sample < prior_sample_q;

  always_comb begin
    if (rise) begin
      new_mark = MARK_PEAK;
    end else if (fall) begin
      new_mark = MARK_TROUGH;
    end else begin
      new_mark = MARK_NEITHER;
    end
  end

  // Revise the held sample's tentative marker
  always_comb begin
    revised = prior_marker_q;
    case (prior_marker_q)
      MARK_NEITHER: begin
        if (rise) begin
          revised = MARK_TROUGH;
        end else if (fall) begin
          revised = MARK_PEAK;
        end
      end
      MARK_PEAK: begin
        if (rise) begin
          revised = MARK_NEITHER;
        end
      end
      MARK_TROUGH: begin
        if (fall) begin
          revised = MARK_NEITHER;
        end
      end
      default: revised = MARK_NEITHER;
    endcase
  end

  // Track running extremes; the first sample of a record seeds both
  always_comb begin
    max_d = max_q;
    min_d = min_q;
    if (!have_prior_q) begin
      max_d = in_i.sample;
      min_d = in_i.sample;
    end else if (in_i.sample > max_q) begin
      max_d = in_i.sample;
    end else if (in_i.sample < min_q) begin
      min_d = in_i.sample;
    end
  end

  assign range = SAMPLE_BITS'(max_d - min_d);

  // Build the result beats for this sample
  always_comb begin
    push_o.mark_vld                = accept_i && have_prior_q;
    push_o.mark_beat.marker        = prior_first_q ? MARK_NEITHER : revised;
    push_o.mark_beat.peak_to_peak  = '0;
    push_o.mark_beat.last_result   = 1'b0;
    push_o.end_vld                 = accept_i && in_i.end_of_record;
    push_o.end_beat.marker         = MARK_NEITHER;
    push_o.end_beat.peak_to_peak   = P2P_BITS'(range);
    push_o.end_beat.last_result    = 1'b1;
  end

  // Advance the held state
  always_comb begin
    prior_sample_d = prior_sample_q;
    prior_marker_d = prior_marker_q;
    have_prior_d   = have_prior_q;
    prior_first_d  = prior_first_q;
    if (accept_i) begin
      prior_sample_d = in_i.sample;
      if (in_i.end_of_record) begin
        have_prior_d   = 1'b0;
        prior_first_d  = 1'b0;
        prior_marker_d = MARK_NEITHER;
      end else begin
        have_prior_d   = 1'b1;
        prior_first_d  = !have_prior_q;
        prior_marker_d = have_prior_q ? new_mark : MARK_NEITHER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_marker_q <= MARK_NEITHER;
      have_prior_q   <= 1'b0;
      prior_first_q  <= 1'b0;
    end else begin
      prior_marker_q <= prior_marker_d;
      have_prior_q   <= have_prior_d;
      prior_first_q  <= prior_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prior_sample_q <= prior_sample_d;
    if (accept_i) begin
      max_q <= max_d;
      min_q <= min_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ptm_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptm_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ptm_pkg::push_t     push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ptm_pkg::out_beat_t      out_o
);
  import ptm_pkg::*;

  out_beat_t             mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_q, wr_d;
  logic [PTR_BITS-1:0]   rd_q, rd_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [1:0]            n_push;
  logic                  pop;
  logic [PTR_BITS-1:0]   end_addr;

  assign n_push      = 2'(push_i.mark_vld) + 2'(push_i.end_vld);
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = mem_q[rd_q];
  // Take a sample only while two free slots remain
  assign room_o      = count_q <= CNT_BITS'(FIFO_DEPTH - 2);
  assign end_addr    = wr_q + PTR_BITS'(push_i.mark_vld);

  // Advance pointers and fill level
  always_comb begin
    wr_d    = wr_q + PTR_BITS'(n_push);
    rd_d    = rd_q + PTR_BITS'(pop);
    count_d = count_q + CNT_BITS'(n_push) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Store up to two beats per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.mark_vld) begin
      mem_q[wr_q] <= push_i.mark_beat;
    end
    if (push_i.end_vld) begin
      mem_q[end_addr] <= push_i.end_beat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/peak_trough_marker.sv @@
// Beats leave a register; each marker is queued when the next sample is accepted.
// Throughput: one sample per cycle; the last sample of a record yields two beats,
// absorbed by a four-entry output queue, and ready drops while three or more wait.
// Reset: asynchronous active low; empties the queue and returns to record start
// with the held marker cleared to neither.
`timescale 1ns / 1ps
`default_nettype none

module peak_trough_marker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ptm_pkg::in_beat_t  in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ptm_pkg::out_beat_t      out_o
);
  import ptm_pkg::*;

  logic  accept;
  logic  room;
  push_t push;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  // Mark samples and track the record range
  ptm_mark u_mark (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .push_o   (push)
  );

  // Queue result beats toward the output
  ptm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
